/* hw/rtl/ppusrt_pkg.sv */
// shared types and constants for the ppu scroll register and timing unit
// no dependencies; every other file in hw/rtl except ppusrt_ram imports this package
`timescale 1ns / 1ps

package ppusrt_pkg;

   // word kinds on the request tuser
   typedef enum logic [1:0] {
      FUNC_TICK  = 2'd0,
      FUNC_READ  = 2'd1,
      FUNC_WRITE = 2'd2,
      FUNC_NONE  = 2'd3
   } func_type;

   // register numbers
   localparam logic [2:0] REG_CTRL     = 3'd0;
   localparam logic [2:0] REG_MASK     = 3'd1;
   localparam logic [2:0] REG_STATUS   = 3'd2;
   localparam logic [2:0] REG_OAM_ADDR = 3'd3;
   localparam logic [2:0] REG_OAM_DATA = 3'd4;
   localparam logic [2:0] REG_SCROLL   = 3'd5;
   localparam logic [2:0] REG_ADDR     = 3'd6;
   localparam logic [2:0] REG_DATA     = 3'd7;

   localparam int SPRITE_MEM_BYTES = 256;
   localparam int DOTS_PER_LINE    = 341;

   // frame position, rows count from the prerender line
   localparam logic [8:0] DOT_LAST        = 9'(DOTS_PER_LINE - 1);
   localparam logic [8:0] ROW_PRERENDER   = 9'd0;
   localparam logic [8:0] ROW_LAST_RENDER = 9'd240;
   localparam logic [8:0] ROW_VBLANK      = 9'd242;
   localparam logic [8:0] ROW_LAST        = 9'd261;
   localparam logic [9:0] WRAP_SCANLINE   = 10'd261;

   localparam logic [8:0] DOT_FLAG_EVENT = 9'd1;
   localparam logic [8:0] DOT_FINE_Y     = 9'd256;
   localparam logic [8:0] DOT_HORZ_COPY  = 9'd257;
   localparam logic [8:0] DOT_VERT_COPY  = 9'd280;
   localparam logic [8:0] DOT_PREFETCH_A = 9'd321;
   localparam logic [8:0] DOT_PREFETCH_B = 9'd329;

   localparam logic [14:0] VERT_COPY_MASK = 15'h7BE0;
   localparam logic [14:0] HORZ_COPY_MASK = 15'h041F;
   localparam logic [13:0] DATA_BUF_LIMIT = 14'h3EFF;

   // current frame position from the timing counter
   typedef struct packed {
      logic       wrap;
      logic [8:0] row;
      logic [8:0] dot;
   } pos_type;

   // one result word
   typedef struct packed {
      logic               frame_done;
      logic [8:0]         dot;
      logic signed [9:0]  scanline;
      logic               nmi;
      logic [13:0]        next_vaddr;
      logic [7:0]         vram_wdata;
      logic [13:0]        vram_addr;
      logic               vram_we;
      logic [7:0]         rdata;
   } rsp_type;

endpackage

/* hw/rtl/ppu_scroll_registers_and_timing_unit.sv */
// Video-chip register file and scroll address unit. Each request word is a dot tick, a
// register read or a register write (kind in req_tuser) and yields exactly one response
// word. A word is accepted every cycle: the register and scroll state update in the cycle
// of acceptance, and the response passes through a holding stage and an output register,
// so a stalled response does not stop the next request until both are full. The holding
// stage lines up with the registered sprite memory read. Sprite memory is cleared at
// reset through per-entry valid bits, with no clearing pass. Ticks advance a 341-dot by
// 262-line counter plus one wrap tick per frame (rsp_tlast), one dot shorter on odd
// frames when background is shown.
// depends on ppusrt_pkg, ppusrt_ram, ppusrt_timing, ppusrt_out_stage
`timescale 1ns / 1ps

module ppu_scroll_registers_and_timing_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // reg_index[2:0], wdata[10:3], vram_rdata[18:11], sprite0_hit[19], zero[23:20]
   input  logic [23:0] req_tdata,
   // func[1:0]
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // rdata[7:0], vram_we[8], vram_addr[22:9], vram_wdata[30:23], next_vaddr[44:31],
   // nmi[45], scanline[55:46], dot[64:56], zero[71:65]
   output logic [71:0] rsp_tdata,
   // frame_done
   output logic        rsp_tlast
);
   import ppusrt_pkg::*;

   localparam int OamAddrW = $clog2(SPRITE_MEM_BYTES);

   logic [2:0]  reg_index;
   logic [7:0]  wdata;
   logic [7:0]  vram_rdata;
   logic        sprite0_hit;
   func_type    func;
   logic        req_acc;

   assign reg_index   = req_tdata[2:0];
   assign wdata       = req_tdata[10:3];
   assign vram_rdata  = req_tdata[18:11];
   assign sprite0_hit = req_tdata[19];
   assign func        = func_type'(req_tuser);
   assign req_acc     = req_tvalid && req_tready;

   logic [7:0]          latch_ff [8];
   logic [7:0]          latch_in [8];
   logic [14:0]         v_ff, v_in;
   logic [14:0]         t_ff, t_in;
   logic                toggle_ff, toggle_in;
   logic [5:0]          ahl_ff, ahl_in;
   logic [7:0]          rbuf_ff, rbuf_in;
   logic [OamAddrW-1:0] oam_addr_ff, oam_addr_in;
   logic [SPRITE_MEM_BYTES-1:0] oam_vld_ff;
   logic                oam_rd_vld_ff;
   logic                oam_we;
   logic                use_ram;
   logic [7:0]          ram_dout;
   logic [7:0]          ram_byte;
   logic                load_ready;
   rsp_type             res;
   rsp_type             out_data;
   pos_type             pos;
   logic                render;
   logic [13:0]         data_step;

   function automatic logic [14:0] step_coarse_x(input logic [14:0] v);
      if (v[4:0] == 5'd31) begin
         return (v & 15'h7FE0) ^ 15'h0400;
      end
      return v + 15'd1;
   endfunction

   function automatic logic [14:0] step_fine_y(input logic [14:0] v);
      logic [4:0]  row;
      logic [14:0] r;
      if (v[14:12] != 3'd7) begin
         return v + 15'h1000;
      end
      row = v[9:5];
      r   = v & 15'h0C1F;
      if (row == 5'd29) begin
         row = 5'd0;
         r   = r ^ 15'h0800;
      end else if (row == 5'd31) begin
         row = 5'd0;
      end else begin
         row = row + 5'd1;
      end
      return r | {5'd0, row, 5'd0};
   endfunction

   assign render    = (latch_ff[REG_MASK][4:3] != 2'b00);
   assign data_step = latch_ff[REG_CTRL][2] ? 14'd32 : 14'd1;

   always_comb begin
      latch_in    = latch_ff;
      v_in        = v_ff;
      t_in        = t_ff;
      toggle_in   = toggle_ff;
      ahl_in      = ahl_ff;
      rbuf_in     = rbuf_ff;
      oam_addr_in = oam_addr_ff;
      oam_we      = 1'b0;
      use_ram     = 1'b0;
      res         = '0;
      if (req_acc) begin
         case (func)
            FUNC_TICK: begin
               if (pos.wrap) begin
                  res.frame_done = 1'b1;
                  res.scanline   = WRAP_SCANLINE;
               end else begin
                  res.scanline = {1'b0, pos.row} - 10'd1;
                  res.dot      = pos.dot;
                  if (pos.row == ROW_PRERENDER && pos.dot == DOT_FLAG_EVENT) begin
                     latch_in[REG_STATUS][7:6] = 2'b00;
                  end
                  if (render && pos.row <= ROW_LAST_RENDER) begin
                     if (pos.row == ROW_PRERENDER) begin
                        if (pos.dot == DOT_VERT_COPY) begin
                           v_in = (v_ff & ~VERT_COPY_MASK) | (t_ff & VERT_COPY_MASK);
                        end
                     end else if (pos.dot != 9'd0 && pos.dot < DOT_FINE_Y
                                  && pos.dot[2:0] == 3'd0) begin
                        v_in = step_coarse_x(v_ff);
                     end
                     if (pos.dot == DOT_FINE_Y) begin
                        v_in = step_fine_y(v_ff);
                     end
                     if (pos.dot == DOT_HORZ_COPY) begin
                        v_in = (v_ff & ~HORZ_COPY_MASK) | (t_ff & HORZ_COPY_MASK);
                     end
                     if (pos.dot == DOT_PREFETCH_A || pos.dot == DOT_PREFETCH_B) begin
                        v_in = step_coarse_x(v_ff);
                     end
                  end else if (pos.row == ROW_VBLANK && pos.dot == DOT_FLAG_EVENT) begin
                     latch_in[REG_STATUS][7] = 1'b1;
                     res.nmi = latch_ff[REG_CTRL][7];
                  end
               end
               if (sprite0_hit) begin
                  latch_in[REG_STATUS][6] = 1'b1;
               end
            end
            FUNC_READ: begin
               res.rdata = latch_ff[reg_index];
               case (reg_index)
                  REG_STATUS: begin
                     latch_in[REG_STATUS][7] = 1'b0;
                     toggle_in = 1'b0;
                  end
                  REG_OAM_DATA: begin
                     use_ram = 1'b1;
                  end
                  REG_DATA: begin
                     // palette range bypasses the read buffer
                     if (v_ff[13:0] <= DATA_BUF_LIMIT) begin
                        res.rdata = rbuf_ff;
                        rbuf_in   = vram_rdata;
                     end else begin
                        res.rdata = vram_rdata;
                     end
                     res.vram_addr = v_ff[13:0];
                     v_in = {1'b0, v_ff[13:0] + data_step};
                  end
                  default: begin
                  end
               endcase
            end
            FUNC_WRITE: begin
               latch_in[reg_index] = wdata;
               case (reg_index)
                  REG_CTRL: begin
                     t_in[11:10] = wdata[1:0];
                  end
                  REG_OAM_ADDR: begin
                     oam_addr_in = wdata[OamAddrW-1:0];
                  end
                  REG_OAM_DATA: begin
                     oam_we      = 1'b1;
                     oam_addr_in = oam_addr_ff + 1'b1;
                  end
                  REG_SCROLL: begin
                     if (!toggle_ff) begin
                        t_in[4:0] = wdata[7:3];
                     end else begin
                        t_in[14:12] = wdata[2:0];
                        t_in[9:5]   = wdata[7:3];
                     end
                     toggle_in = ~toggle_ff;
                  end
                  REG_ADDR: begin
                     if (!toggle_ff) begin
                        ahl_in = wdata[5:0];
                     end else begin
                        v_in = {1'b0, ahl_ff, wdata};
                     end
                     toggle_in = ~toggle_ff;
                  end
                  REG_DATA: begin
                     res.vram_we    = 1'b1;
                     res.vram_addr  = v_ff[13:0];
                     res.vram_wdata = wdata;
                     v_in = {1'b0, v_ff[13:0] + data_step};
                  end
                  default: begin
                  end
               endcase
            end
            default: begin
            end
         endcase
      end
      res.next_vaddr = v_in[13:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 8; i++) begin
            latch_ff[i] <= 8'd0;
         end
         v_ff          <= '0;
         t_ff          <= '0;
         toggle_ff     <= 1'b0;
         ahl_ff        <= '0;
         rbuf_ff       <= '0;
         oam_addr_ff   <= '0;
         oam_vld_ff    <= '0;
         oam_rd_vld_ff <= 1'b0;
      end else begin
         latch_ff    <= latch_in;
         v_ff        <= v_in;
         t_ff        <= t_in;
         toggle_ff   <= toggle_in;
         ahl_ff      <= ahl_in;
         rbuf_ff     <= rbuf_in;
         oam_addr_ff <= oam_addr_in;
         if (oam_we) begin
            oam_vld_ff[oam_addr_ff] <= 1'b1;
         end
         // valid bit travels with the registered ram read
         if (req_acc) begin
            oam_rd_vld_ff <= oam_vld_ff[oam_addr_ff];
         end
      end
   end

   ppusrt_timing u_timing (
      .clock   (clock),
      .reset   (reset),
      .tick_en (req_acc && func == FUNC_TICK),
      .skip_en (latch_ff[REG_MASK][3]),
      .pos     (pos)
   );

   ppusrt_ram #(
      .WIDTH (8),
      .DEPTH (SPRITE_MEM_BYTES)
   ) u_oam (
      .clock   (clock),
      .wr_en   (oam_we),
      .wr_addr (oam_addr_ff),
      .wr_data (wdata),
      .rd_en   (req_acc),
      .rd_addr (oam_addr_ff),
      .rd_data (ram_dout)
   );

   assign ram_byte = oam_rd_vld_ff ? ram_dout : 8'd0;

   ppusrt_out_stage u_out (
      .clock        (clock),
      .reset        (reset),
      .load         (req_acc),
      .load_data    (res),
      .load_use_ram (use_ram),
      .load_ready   (load_ready),
      .ram_byte     (ram_byte),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .out_data     (out_data)
   );

   assign req_tready = load_ready;
   assign rsp_tdata  = {7'd0, out_data.dot, out_data.scanline, out_data.nmi,
                        out_data.next_vaddr, out_data.vram_wdata, out_data.vram_addr,
                        out_data.vram_we, out_data.rdata};
   assign rsp_tlast  = out_data.frame_done;

   a_status_read_clears: assert property (@(posedge clock) disable iff (reset)
      req_acc && func == FUNC_READ && reg_index == REG_STATUS
      |=> !toggle_ff && !latch_ff[REG_STATUS][7])
      else $error("status read left vblank flag or write toggle set");

   a_oam_addr_step: assert property (@(posedge clock) disable iff (reset)
      req_acc && func == FUNC_WRITE && reg_index == REG_OAM_DATA
      |=> oam_addr_ff == $past(oam_addr_ff) + 1'b1)
      else $error("sprite address did not step after data write");

   a_v_high_bit_on_data: assert property (@(posedge clock) disable iff (reset)
      req_acc && reg_index == REG_DATA && (func == FUNC_READ || func == FUNC_WRITE)
      |=> !v_ff[14])
      else $error("data port access left video address bit 14 set");

endmodule

/* hw/rtl/ppusrt_ram.sv */
// generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module ppusrt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int AddrW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AddrW-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/ppusrt_timing.sv */
// frame timing counter: 341 dots by 262 lines plus the wrap tick, odd frame skip
// depends on ppusrt_pkg
`timescale 1ns / 1ps

module ppusrt_timing (
   input  logic              clock,
   input  logic              reset,
   input  logic              tick_en,
   input  logic              skip_en,
   output ppusrt_pkg::pos_type pos
);
   import ppusrt_pkg::*;

   logic       wrap_ff, wrap_in;
   logic [8:0] row_ff, row_in;
   logic [8:0] dot_ff, dot_in;
   logic       odd_ff, odd_in;

   always_comb begin
      wrap_in = wrap_ff;
      row_in  = row_ff;
      dot_in  = dot_ff;
      odd_in  = odd_ff;
      if (tick_en) begin
         if (wrap_ff) begin
            // odd frames with background on start one dot late
            wrap_in = 1'b0;
            row_in  = ROW_PRERENDER;
            dot_in  = (odd_ff && skip_en) ? 9'd1 : 9'd0;
            odd_in  = ~odd_ff;
         end else if (dot_ff == DOT_LAST) begin
            dot_in = 9'd0;
            if (row_ff == ROW_LAST) begin
               wrap_in = 1'b1;
            end else begin
               row_in = row_ff + 9'd1;
            end
         end else begin
            dot_in = dot_ff + 9'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wrap_ff <= 1'b0;
         row_ff  <= ROW_PRERENDER;
         dot_ff  <= 9'd0;
         odd_ff  <= 1'b0;
      end else begin
         wrap_ff <= wrap_in;
         row_ff  <= row_in;
         dot_ff  <= dot_in;
         odd_ff  <= odd_in;
      end
   end

   assign pos.wrap = wrap_ff;
   assign pos.row  = row_ff;
   assign pos.dot  = dot_ff;

endmodule

/* hw/rtl/ppusrt_out_stage.sv */
// two-deep result stage: holding register beside the sprite ram read, then output register
// depends on ppusrt_pkg
`timescale 1ns / 1ps

module ppusrt_out_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  ppusrt_pkg::rsp_type load_data,
   input  logic                load_use_ram,
   output logic                load_ready,
   input  logic [7:0]          ram_byte,
   output logic                out_valid,
   input  logic                out_ready,
   output ppusrt_pkg::rsp_type out_data
);
   import ppusrt_pkg::*;

   logic    s1_vld_ff;
   rsp_type s1_data_ff;
   logic    s1_ram_ff;
   logic    out_vld_ff;
   rsp_type out_data_ff;
   rsp_type s1_final;
   logic    move;

   assign move       = s1_vld_ff && (!out_vld_ff || out_ready);
   assign load_ready = !s1_vld_ff || move;

   // sprite data reads take the byte from the ram, which lines up with this stage
   always_comb begin
      s1_final = s1_data_ff;
      if (s1_ram_ff) begin
         s1_final.rdata = ram_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         if (load) begin
            s1_vld_ff <= 1'b1;
         end else if (move) begin
            s1_vld_ff <= 1'b0;
         end
         if (move) begin
            out_vld_ff <= 1'b1;
         end else if (out_ready) begin
            out_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         s1_data_ff <= load_data;
         s1_ram_ff  <= load_use_ram;
      end
      if (move) begin
         out_data_ff <= s1_final;
      end
   end

   assign out_valid = out_vld_ff;
   assign out_data  = out_data_ff;

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      load |-> load_ready)
      else $error("word loaded while holding stage is blocked");

   a_hold_blocked: assert property (@(posedge clock) disable iff (reset)
      s1_vld_ff && out_vld_ff && !out_ready && !load |=> s1_vld_ff && $stable(s1_data_ff))
      else $error("holding stage lost a word while output stalled");

   a_move_fills: assert property (@(posedge clock) disable iff (reset)
      move |=> out_vld_ff)
      else $error("word moved but output register empty");

endmodule

/* test/ppu_scroll_registers_and_timing_unit_checker.sv */
`timescale 1ns / 1ps
// response checker for the ppu scroll register and timing unit: keeps its own copy of the
// register, scroll address and frame timing state and compares every response word
// depends on ppusrt_pkg
module ppu_scroll_registers_and_timing_unit_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   // reg_index[2:0], wdata[10:3], vram_rdata[18:11], sprite0_hit[19], zero[23:20]
   input  logic [23:0] req_tdata,
   // func[1:0]
   input  logic [1:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   // rdata[7:0], vram_we[8], vram_addr[22:9], vram_wdata[30:23], next_vaddr[44:31],
   // nmi[45], scanline[55:46], dot[64:56], zero[71:65]
   input  logic [71:0] rsp_tdata,
   // frame_done
   input  logic        rsp_tlast,
   output int          error_count,
   output int          pending_count
);
   import ppusrt_pkg::*;

   localparam int LINES_PER_FRAME  = 262;
   localparam int TICKS_PER_FRAME  = DOTS_PER_LINE * LINES_PER_FRAME;
   localparam int LAST_RENDER_LINE = 239;
   localparam int VBLANK_LINE      = 241;
   localparam logic [14:0] VERT_BITS    = 15'h7BE0;
   localparam logic [14:0] HORZ_BITS    = 15'h041F;
   localparam logic [13:0] BUFFERED_TOP = 14'h3EFF;
   localparam int MAX_REPORTS = 20;

   logic [7:0]  reg_byte [8];
   logic [7:0]  sprite_ram [SPRITE_MEM_BYTES];
   logic [14:0] vaddr;
   logic [14:0] taddr;
   logic [5:0]  addr_high;
   logic [7:0]  data_buffer;
   logic [7:0]  sprite_addr;
   logic        second_write;
   logic        odd_frame;
   int          ticks_left;
   rsp_type     rsp_words_due [$];
   rsp_type     want;
   rsp_type     got;

   function automatic logic [14:0] coarse_x_inc(logic [14:0] v);
      // coarse x wraps into the neighboring nametable
      if (v[4:0] == 5'd31) return (v & 15'h7FE0) ^ 15'h0400;
      return v + 15'd1;
   endfunction

   function automatic logic [14:0] fine_y_inc(logic [14:0] v);
      logic [4:0]  row;
      logic [14:0] r;
      if (v[14:12] != 3'b111) return v + 15'h1000;
      row = v[9:5];
      r = v & 15'h0C1F;
      if (row == 5'd29) begin
         row = 5'd0;
         r = r ^ 15'h0800;
      end else if (row == 5'd31) begin
         row = 5'd0;
      end else begin
         row = row + 5'd1;
      end
      return r | {5'd0, row, 5'd0};
   endfunction

   function automatic rsp_type predict_rsp(func_type kind, logic [2:0] idx, logic [7:0] wd,
                                           logic [7:0] vd, logic hit);
      rsp_type     r;
      int          tick;
      int          line;
      int          d;
      logic        render;
      logic [13:0] a;
      logic [13:0] step;
      r = '0;
      step = reg_byte[REG_CTRL][2] ? 14'd32 : 14'd1;
      case (kind)
         FUNC_TICK: begin
            if (ticks_left == 0) begin
               r.frame_done = 1'b1;
               r.scanline = 10'(LINES_PER_FRAME - 1);
               ticks_left = TICKS_PER_FRAME;
               if (odd_frame && reg_byte[REG_MASK][3]) ticks_left--;
               odd_frame = ~odd_frame;
            end else begin
               tick = TICKS_PER_FRAME - ticks_left;
               line = tick / DOTS_PER_LINE - 1;
               d = tick % DOTS_PER_LINE;
               render = reg_byte[REG_MASK][4] | reg_byte[REG_MASK][3];
               r.scanline = 10'(line);
               r.dot = 9'(d);
               if (line == -1 && d == 1) reg_byte[REG_STATUS][7:6] = 2'b00;
               if (render && line >= -1 && line <= LAST_RENDER_LINE) begin
                  if (line == -1) begin
                     if (d == 280) vaddr = (vaddr & ~VERT_BITS) | (taddr & VERT_BITS);
                  end else if (d > 0 && d < 256 && d % 8 == 0) begin
                     vaddr = coarse_x_inc(vaddr);
                  end
                  if (d == 256) vaddr = fine_y_inc(vaddr);
                  if (d == 257) vaddr = (vaddr & ~HORZ_BITS) | (taddr & HORZ_BITS);
                  if (d == 321 || d == 329) vaddr = coarse_x_inc(vaddr);
               end else if (line == VBLANK_LINE && d == 1) begin
                  reg_byte[REG_STATUS][7] = 1'b1;
                  r.nmi = reg_byte[REG_CTRL][7];
               end
               ticks_left--;
            end
            if (hit) reg_byte[REG_STATUS][6] = 1'b1;
         end
         FUNC_READ: begin
            r.rdata = reg_byte[idx];
            case (idx)
               REG_STATUS: begin
                  reg_byte[REG_STATUS][7] = 1'b0;
                  second_write = 1'b0;
               end
               REG_OAM_DATA: r.rdata = sprite_ram[sprite_addr];
               REG_DATA: begin
                  a = vaddr[13:0];
                  // palette range bypasses the read buffer
                  if (a <= BUFFERED_TOP) begin
                     r.rdata = data_buffer;
                     data_buffer = vd;
                  end else begin
                     r.rdata = vd;
                  end
                  r.vram_addr = a;
                  vaddr = {1'b0, a + step};
               end
               default: ;
            endcase
         end
         FUNC_WRITE: begin
            reg_byte[idx] = wd;
            case (idx)
               REG_CTRL: taddr[11:10] = wd[1:0];
               REG_OAM_ADDR: sprite_addr = wd;
               REG_OAM_DATA: begin
                  sprite_ram[sprite_addr] = wd;
                  sprite_addr = sprite_addr + 8'd1;
               end
               REG_SCROLL: begin
                  if (!second_write) begin
                     taddr[4:0] = wd[7:3];
                  end else begin
                     taddr[14:12] = wd[2:0];
                     taddr[9:5] = wd[7:3];
                  end
                  second_write = ~second_write;
               end
               REG_ADDR: begin
                  if (!second_write) addr_high = wd[5:0];
                  else vaddr = {1'b0, addr_high, wd};
                  second_write = ~second_write;
               end
               REG_DATA: begin
                  r.vram_we = 1'b1;
                  r.vram_addr = vaddr[13:0];
                  r.vram_wdata = wd;
                  vaddr = {1'b0, vaddr[13:0] + step};
               end
               default: ;
            endcase
         end
         default: ;
      endcase
      r.next_vaddr = vaddr[13:0];
      return r;
   endfunction

   task automatic compare_field(string name, int want_v, int got_v);
      if (want_v != got_v) begin
         if (error_count < MAX_REPORTS)
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want_v, got_v);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         foreach (reg_byte[i]) reg_byte[i] = '0;
         foreach (sprite_ram[i]) sprite_ram[i] = '0;
         vaddr = '0;
         taddr = '0;
         addr_high = '0;
         data_buffer = '0;
         sprite_addr = '0;
         second_write = 1'b0;
         odd_frame = 1'b0;
         ticks_left = TICKS_PER_FRAME;
         rsp_words_due.delete();
      end else begin
         if (req_tvalid && req_tready)
            rsp_words_due.push_back(predict_rsp(func_type'(req_tuser), req_tdata[2:0],
                                                req_tdata[10:3], req_tdata[18:11],
                                                req_tdata[19]));
         if (rsp_tvalid && rsp_tready) begin
            got.rdata = rsp_tdata[7:0];
            got.vram_we = rsp_tdata[8];
            got.vram_addr = rsp_tdata[22:9];
            got.vram_wdata = rsp_tdata[30:23];
            got.next_vaddr = rsp_tdata[44:31];
            got.nmi = rsp_tdata[45];
            got.scanline = rsp_tdata[55:46];
            got.dot = rsp_tdata[64:56];
            got.frame_done = rsp_tlast;
            if (rsp_words_due.size() == 0) begin
               if (error_count < MAX_REPORTS)
                  $display("%0t ns: unexpected response word, expected none, got %h",
                           $time, rsp_tdata);
               error_count++;
            end else begin
               want = rsp_words_due.pop_front();
               compare_field("rdata", want.rdata, got.rdata);
               compare_field("vram_we", want.vram_we, got.vram_we);
               compare_field("vram_addr", want.vram_addr, got.vram_addr);
               compare_field("vram_wdata", want.vram_wdata, got.vram_wdata);
               compare_field("next_vaddr", want.next_vaddr, got.next_vaddr);
               compare_field("nmi", want.nmi, got.nmi);
               compare_field("scanline", want.scanline, got.scanline);
               compare_field("dot", want.dot, got.dot);
               compare_field("frame_done", want.frame_done, got.frame_done);
            end
         end
      end
      pending_count = rsp_words_due.size();
   end

endmodule

/* test/ppu_scroll_registers_and_timing_unit_tb.sv */
`timescale 1ns / 1ps
// testbench top for the ppu scroll register and timing unit: drives register and tick
// words with bursty traffic and a stalling receiver, then gives the verdict
// depends on ppusrt_pkg, the unit and ppu_scroll_registers_and_timing_unit_checker
module ppu_scroll_registers_and_timing_unit_tb;
   import ppusrt_pkg::*;

   localparam int RANDOM_WORDS = 400;
   // short tick run with rendering on to exercise the scroll increments and copies
   localparam int SWEEP_TICKS  = 120;
   localparam int CYCLE_LIMIT  = 3000000;
   localparam int DRAIN_CYCLES = 20;

   typedef enum int {
      READY_ALWAYS,
      READY_MOST,
      READY_HALF,
      READY_PERIODIC
   } ready_kind;

   typedef enum int {
      ACC_TICKS,
      ACC_SCROLL,
      ACC_ADDR_DATA,
      ACC_SPRITE,
      ACC_STATUS,
      ACC_SETUP,
      ACC_READ,
      ACC_NOISE
   } access_kind;

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata  = '0;
   logic [1:0]  req_tuser  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;
   logic        rsp_tlast;

   int          error_count;
   int          pending_count;
   int          cycle_count = 0;
   int          burst_left = 0;
   int          words_sent = 0;
   logic        keep_render = 1'b0;
   ready_kind   stall_mode = READY_ALWAYS;
   int          stall_left = 0;
   int          stall_phase = 0;

   ppu_scroll_registers_and_timing_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   ppu_scroll_registers_and_timing_unit_checker u_check (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // receiver switches between stall patterns, each held for a random stretch
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= ready_kind'($urandom_range(0, 3));
         stall_left <= $urandom_range(64, 512);
      end else begin
         stall_left <= stall_left - 1;
      end
      stall_phase <= stall_phase + 1;
      case (stall_mode)
         READY_ALWAYS: rsp_tready <= 1'b1;
         READY_MOST:   rsp_tready <= ($urandom_range(0, 3) != 0);
         READY_HALF:   rsp_tready <= 1'($urandom_range(0, 1));
         default:      rsp_tready <= (stall_phase % 3 != 0);
      endcase
   end

   task automatic send_word(func_type kind, logic [2:0] idx, logic [7:0] wd,
                            logic [7:0] vd, logic hit);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 64);
         if ($urandom_range(0, 3) != 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata <= {4'd0, hit, vd, wd, idx};
      req_tuser <= kind;
      // ready is stable from the falling edge to the next rising edge
      @(negedge clock);
      while (!req_tready) @(negedge clock);
      @(posedge clock);
      burst_left--;
      if (kind != FUNC_NONE) words_sent++;
   endtask

   task automatic write_reg(logic [2:0] idx, logic [7:0] wd);
      logic [7:0] v;
      v = wd;
      if (keep_render && $urandom_range(0, 3) != 0) begin
         if (idx == REG_MASK) v[4:3] = 2'b11;
         if (idx == REG_CTRL) v[7] = 1'b1;
      end
      send_word(FUNC_WRITE, idx, v, 8'($urandom), 1'($urandom));
   endtask

   task automatic read_reg(logic [2:0] idx);
      send_word(FUNC_READ, idx, 8'($urandom), 8'($urandom), 1'($urandom));
   endtask

   task automatic send_ticks(int n);
      repeat (n) send_word(FUNC_TICK, 3'($urandom), 8'($urandom), 8'($urandom),
                           $urandom_range(0, 15) == 0);
   endtask

   task automatic random_access(logic allow_ticks);
      access_kind k;
      int         n;
      k = access_kind'($urandom_range(allow_ticks ? 0 : 1, 7));
      n = $urandom_range(1, 6);
      case (k)
         ACC_TICKS: send_ticks($urandom_range(1, 40));
         ACC_SCROLL: repeat (2) write_reg(REG_SCROLL, 8'($urandom));
         ACC_ADDR_DATA: begin
            write_reg(REG_ADDR, $urandom_range(0, 3) == 0 ? 8'h3F : 8'($urandom));
            write_reg(REG_ADDR, 8'($urandom));
            repeat (n) begin
               if ($urandom_range(0, 1)) write_reg(REG_DATA, 8'($urandom));
               else read_reg(REG_DATA);
            end
         end
         ACC_SPRITE: begin
            write_reg(REG_OAM_ADDR, 8'($urandom));
            repeat (n) begin
               if ($urandom_range(0, 1)) write_reg(REG_OAM_DATA, 8'($urandom));
               else read_reg(REG_OAM_DATA);
            end
         end
         ACC_STATUS: begin
            read_reg(REG_STATUS);
            if ($urandom_range(0, 1)) write_reg(REG_SCROLL, 8'($urandom));
         end
         ACC_SETUP: write_reg($urandom_range(0, 1) ? REG_CTRL : REG_MASK, 8'($urandom));
         ACC_READ: read_reg(3'($urandom));
         default: send_word(func_type'($urandom_range(0, 3)), 3'($urandom), 8'($urandom),
                            8'($urandom), 1'($urandom));
      endcase
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // register latches, nmi enable and +32 step
      write_reg(REG_CTRL, 8'hFF);
      read_reg(REG_CTRL);
      write_reg(REG_MASK, 8'h00);
      read_reg(REG_MASK);
      write_reg(REG_SCROLL, 8'hFF);
      write_reg(REG_SCROLL, 8'h00);
      // palette read bypasses the buffer, then the address wraps at the top
      write_reg(REG_ADDR, 8'h3F);
      write_reg(REG_ADDR, 8'h00);
      send_word(FUNC_READ, REG_DATA, 8'h00, 8'hAA, 1'b0);
      write_reg(REG_CTRL, 8'h00);
      write_reg(REG_ADDR, 8'hFF);
      write_reg(REG_ADDR, 8'hFF);
      send_word(FUNC_READ, REG_DATA, 8'hFF, 8'h00, 1'b1);
      send_word(FUNC_READ, REG_DATA, 8'h00, 8'hFF, 1'b0);
      write_reg(REG_DATA, 8'h5A);
      // sprite address wraps after the last entry
      write_reg(REG_OAM_ADDR, 8'hFF);
      write_reg(REG_OAM_DATA, 8'h81);
      read_reg(REG_OAM_DATA);
      write_reg(REG_OAM_ADDR, 8'hFF);
      read_reg(REG_OAM_DATA);
      // status read clears vblank and the write toggle
      write_reg(REG_STATUS, 8'hC0);
      write_reg(REG_SCROLL, 8'h12);
      read_reg(REG_STATUS);
      write_reg(REG_ADDR, 8'h21);
      // sprite zero hit, then the prerender clear one dot later
      send_word(FUNC_TICK, 3'd0, 8'h00, 8'h00, 1'b1);
      send_word(FUNC_TICK, 3'd7, 8'hFF, 8'hFF, 1'b0);
      read_reg(REG_STATUS);
      send_word(FUNC_NONE, 3'd7, 8'hFF, 8'hFF, 1'b1);

      words_sent = 0;
      while (words_sent < RANDOM_WORDS) random_access(1'b1);

      // tick run with rendering mostly on, register words sprinkled in
      keep_render = 1'b1;
      write_reg(REG_CTRL, 8'h80);
      write_reg(REG_MASK, 8'h18);
      repeat (SWEEP_TICKS) begin
         if ($urandom_range(0, 149) == 0) random_access(1'b0);
         send_ticks(1);
      end
      req_tvalid <= 1'b0;

      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (error_count == 0 && pending_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
